// ===== design/fse_pkg.sv =====
// ----------------------------------------------------------------------------
// Frenet segment error package
// Shared constants, payload types and arithmetic helpers of the core.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int DIV_STEPS    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int WRAP_LAT     = 5;
  localparam int WRAP_IN_W    = 34;

  localparam longint unsigned PI60     = 64'h3243F6A8885A308D;
  localparam longint unsigned PI_F     =
    (PI60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam longint unsigned TWO_PI_F =
    (PI60 + (64'd1 << (58 - FRAC_BITS))) >> (59 - FRAC_BITS);
  localparam int ANG_W = $clog2(TWO_PI_F + 64'd1);

  localparam int RECIP_SHIFT = WRAP_IN_W;
  localparam longint unsigned WRAP_RECIP = (64'd1 << RECIP_SHIFT) / TWO_PI_F;
  localparam int RECIP_W = $clog2(WRAP_RECIP + 64'd1);
  localparam int QUOT_W  = WRAP_IN_W - ANG_W + 1;

  localparam longint unsigned ZERO_LEN_MAX =
    (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;
  localparam logic [30:0]        T_ONE       = 31'h40000000;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_heading;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_heading;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] lateral_error;
    logic signed [31:0] heading_error;
  } result_t;

  // Arctangent of 2^-idx in Q30.
  function automatic logic signed [33:0] atan_q30(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction

  // Divide by 2^n and round half away from zero.
  function automatic longint rnd_half(input longint v, input int n);
    longint unsigned m;
    m = (v < 0) ? $unsigned(-v) : $unsigned(v);
    m = (m + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

endpackage

// ===== design/fse_wrap.sv =====
// ----------------------------------------------------------------------------
// Angle wrap unit
// Reduces an angle into the range about (-pi, pi] by a reciprocal multiply,
// one correction step and a fold, over five register stages.
// ----------------------------------------------------------------------------
module fse_wrap (
  input  logic                                  clk,
  input  logic signed [fse_pkg::WRAP_IN_W-1:0]  a,
  output logic signed [31:0]                    r
);
  import fse_pkg::*;

  logic                          neg1, neg2, neg3, neg4;
  logic [WRAP_IN_W-1:0]          mag1, mag2;
  logic [WRAP_IN_W+RECIP_W-1:0]  prod2;
  logic [QUOT_W-1:0]             quot;
  logic [63:0]                   sub3;
  logic [ANG_W:0]                rem3;
  logic [ANG_W-1:0]              rem4;
  logic [ANG_W-1:0]              mod4;
  logic signed [31:0]            res4;

  always_comb begin
    quot = QUOT_W'(prod2 >> RECIP_SHIFT);
    sub3 = 64'(mag2) - 64'(quot) * 64'(TWO_PI_F);
    mod4 = (neg4 && rem4 != '0) ? ANG_W'(ANG_W'(TWO_PI_F) - rem4) : rem4;
    if (64'(mod4) > PI_F) begin
      res4 = 32'(longint'(mod4) - longint'(TWO_PI_F));
    end else begin
      res4 = 32'(mod4);
    end
  end

  always_ff @(posedge clk) begin
    neg1  <= a[WRAP_IN_W-1];
    mag1  <= a[WRAP_IN_W-1] ? WRAP_IN_W'(-a) : WRAP_IN_W'(a);
    neg2  <= neg1;
    mag2  <= mag1;
    prod2 <= (WRAP_IN_W+RECIP_W)'(mag1) * (WRAP_IN_W+RECIP_W)'(WRAP_RECIP);
    neg3  <= neg2;
    rem3  <= sub3[ANG_W:0];
    neg4  <= neg3;
    if (rem3 >= (ANG_W+1)'(TWO_PI_F)) begin
      rem4 <= ANG_W'(rem3 - (ANG_W+1)'(TWO_PI_F));
    end else begin
      rem4 <= rem3[ANG_W-1:0];
    end
    r <= res4;
  end

endmodule

// ===== design/fse_cordic.sv =====
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Fully pipelined rotation CORDIC in Q30, one iteration per register stage.
// ----------------------------------------------------------------------------
module fse_cordic (
  input  logic               clk,
  input  logic signed [33:0] z_in,
  output logic signed [32:0] x_out,
  output logic signed [32:0] y_out
);
  import fse_pkg::*;

  logic signed [32:0] xs [CORDIC_STEPS];
  logic signed [32:0] ys [CORDIC_STEPS];
  logic signed [33:0] zs [CORDIC_STEPS];
  logic signed [32:0] xp [CORDIC_STEPS];
  logic signed [32:0] yp [CORDIC_STEPS];
  logic signed [33:0] zp [CORDIC_STEPS];
  logic signed [32:0] xn [CORDIC_STEPS];
  logic signed [32:0] yn [CORDIC_STEPS];
  logic signed [33:0] zn [CORDIC_STEPS];

  always_comb begin
    xp[0] = CORDIC_GAIN;
    yp[0] = '0;
    zp[0] = z_in;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      xp[i] = xs[i-1];
      yp[i] = ys[i-1];
      zp[i] = zs[i-1];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (!zp[i][33]) begin
        xn[i] = xp[i] - (yp[i] >>> i);
        yn[i] = yp[i] + (xp[i] >>> i);
        zn[i] = zp[i] - atan_q30(i);
      end else begin
        xn[i] = xp[i] + (yp[i] >>> i);
        yn[i] = yp[i] - (xp[i] >>> i);
        zn[i] = zp[i] + atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs[i] <= xn[i];
      ys[i] <= yn[i];
      zs[i] <= zn[i];
    end
  end

  assign x_out = xs[CORDIC_STEPS-1];
  assign y_out = ys[CORDIC_STEPS-1];

endmodule

// ===== design/frenet_segment_error_core.sv =====
// ----------------------------------------------------------------------------
// Frenet segment error core
// Lateral and heading error of a vehicle pose against one reference segment.
// ----------------------------------------------------------------------------
// The core accepts one transaction in every clock cycle and never raises
// busy. Each transaction returns its result at the end of the pipeline,
// marked by done for one cycle; results leave in order and the
// receiver must take them when they appear. The pipeline is made of the
// 30-stage restoring division that finds the projection parameter, the
// 30-stage CORDIC that gives sine and cosine, one five-stage angle wrap
// unit in front of the CORDIC, and thirteen stages of setup, blending and
// output arithmetic, all fully pipelined.
module frenet_segment_error_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fse_pkg::cmd_t    cmd,
  output logic             done,
  output fse_pkg::result_t result
);
  import fse_pkg::*;

  localparam int LAT    = 13 + DIV_STEPS + WRAP_LAT + CORDIC_STEPS;
  localparam int DH_DLY = DIV_STEPS + 5 - WRAP_LAT;
  localparam logic signed [31:0] PI_S    = 32'(PI_F);
  localparam logic signed [31:0] TRIG_MAX = 32'sd268435712;
  localparam longint SAT_MAX = 64'sd2147483647;
  localparam longint SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [32:0] abx;
    logic signed [32:0] aby;
    logic signed [32:0] apx;
    logic signed [32:0] apy;
    logic signed [31:0] th;
    logic signed [31:0] h0;
  } side_t;

  typedef struct packed {
    logic [63:0]          rem;
    logic [63:0]          den;
    logic [DIV_STEPS-1:0] quo;
    logic                 t_zero;
    logic                 t_one;
    side_t                side;
  } div_t;

  typedef struct packed {
    logic signed [34:0] dx;
    logic signed [34:0] dy;
  } dxy_t;

  typedef struct packed {
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [31:0] ep;
    logic               neg;
  } late_t;

  logic [LAT-1:0] vld;

  side_t              sd1, sd2, sd3, sd4, sd36, sd37;
  logic signed [32:0] dh1;
  logic signed [31:0] dhw6;
  logic signed [31:0] dh_line [DH_DLY];

  logic [31:0]        magx1, magy1, mor1;
  logic [1:0]         sh1, sh2, sh3;
  logic [20:0]        l2_1;
  logic               zl1, zl2, zl3, zl4;
  logic signed [29:0] sbx2, sby2;
  longint             pdx3, pdy3, qx3, qy3;
  longint             dot4;
  logic [63:0]        den4;

  div_t               dv    [DIV_STEPS+1];
  div_t               dv_nx [DIV_STEPS];
  logic [63:0]        shl   [DIV_STEPS];

  logic [30:0]        t36;
  longint             px37, py37, ph37;
  logic signed [31:0] th37;
  logic signed [34:0] dx38, dy38;
  logic signed [33:0] w38, w39, thw39;
  logic signed [31:0] th38;
  dxy_t               dd_line [WRAP_LAT+1];
  logic signed [31:0] ww44, ep44;

  logic signed [33:0] zsc44, zfold44;
  logic               neg44;
  logic signed [33:0] z45;
  late_t              lt_line [CORDIC_STEPS+1];
  logic signed [32:0] x75, y75;
  late_t              lt76;
  logic signed [31:0] cs76, sn76;
  longint             pc77, ps77;
  logic signed [31:0] ep77;
  longint             ey77;

  assign busy = 1'b0;
  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    sd1.abx <= 33'(cmd.seg_end_x) - 33'(cmd.seg_start_x);
    sd1.aby <= 33'(cmd.seg_end_y) - 33'(cmd.seg_start_y);
    sd1.apx <= 33'(cmd.pose_x) - 33'(cmd.seg_start_x);
    sd1.apy <= 33'(cmd.pose_y) - 33'(cmd.seg_start_y);
    sd1.th  <= cmd.pose_heading;
    sd1.h0  <= cmd.seg_start_heading;
    dh1     <= 33'(cmd.seg_end_heading) - 33'(cmd.seg_start_heading);
  end

  fse_wrap u_wrap_dh (
    .clk (clk),
    .a   (WRAP_IN_W'(dh1)),
    .r   (dhw6)
  );

  always_comb begin
    magx1 = sd1.abx[32] ? 32'(-sd1.abx) : 32'(sd1.abx);
    magy1 = sd1.aby[32] ? 32'(-sd1.aby) : 32'(sd1.aby);
    mor1  = magx1 | magy1;
    priority if (mor1[31]) begin
      sh1 = 2'd3;
    end else if (mor1[30]) begin
      sh1 = 2'd2;
    end else if (mor1[29]) begin
      sh1 = 2'd1;
    end else begin
      sh1 = 2'd0;
    end
    l2_1 = 21'(magx1[9:0]) * 21'(magx1[9:0]) + 21'(magy1[9:0]) * 21'(magy1[9:0]);
    zl1  = (magx1 < 32'd1024) && (magy1 < 32'd1024) && (64'(l2_1) <= ZERO_LEN_MAX);
  end

  always_ff @(posedge clk) begin
    sd2  <= sd1;
    sh2  <= sh1;
    zl2  <= zl1;
    sbx2 <= 30'(sd1.abx >>> sh1);
    sby2 <= 30'(sd1.aby >>> sh1);

    sd3  <= sd2;
    sh3  <= sh2;
    zl3  <= zl2;
    pdx3 <= longint'(sd2.apx) * longint'(sbx2);
    pdy3 <= longint'(sd2.apy) * longint'(sby2);
    qx3  <= longint'(sbx2) * longint'(sbx2);
    qy3  <= longint'(sby2) * longint'(sby2);

    sd4  <= sd3;
    zl4  <= zl3;
    dot4 <= pdx3 + pdy3;
    den4 <= $unsigned(qx3 + qy3) << sh3;
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_nx[k] = dv[k];
      shl[k]   = {dv[k].rem[62:0], 1'b0};
      if (shl[k] >= dv[k].den) begin
        dv_nx[k].rem = shl[k] - dv[k].den;
        dv_nx[k].quo = {dv[k].quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        dv_nx[k].rem = shl[k];
        dv_nx[k].quo = {dv[k].quo[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    dv[0].rem    <= $unsigned(dot4);
    dv[0].den    <= den4;
    dv[0].quo    <= '0;
    dv[0].t_zero <= zl4 || (dot4 <= 0) || (den4 == '0);
    dv[0].t_one  <= $unsigned(dot4) >= den4;
    dv[0].side   <= sd4;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv[k+1] <= dv_nx[k];
    end
    dh_line[0] <= dhw6;
    for (int k = 1; k < DH_DLY; k++) begin
      dh_line[k] <= dh_line[k-1];
    end
  end

  always_ff @(posedge clk) begin
    sd36 <= dv[DIV_STEPS].side;
    if (dv[DIV_STEPS].t_zero) begin
      t36 <= '0;
    end else if (dv[DIV_STEPS].t_one) begin
      t36 <= T_ONE;
    end else begin
      t36 <= {1'b0, dv[DIV_STEPS].quo};
    end

    sd37 <= sd36;
    th37 <= sd36.th;
    px37 <= longint'(t36) * longint'(sd36.abx);
    py37 <= longint'(t36) * longint'(sd36.aby);
    ph37 <= longint'(t36) * longint'(dh_line[DH_DLY-1]);

    dx38 <= 35'(longint'(sd37.apx) - rnd_half(px37, 30));
    dy38 <= 35'(longint'(sd37.apy) - rnd_half(py37, 30));
    w38  <= 34'(longint'(sd37.h0) + rnd_half(ph37, 30));
    th38 <= th37;

    w39   <= w38;
    thw39 <= 34'(th38) - w38;
    dd_line[0] <= '{dx: dx38, dy: dy38};
    for (int k = 1; k <= WRAP_LAT; k++) begin
      dd_line[k] <= dd_line[k-1];
    end
  end

  fse_wrap u_wrap_ref (
    .clk (clk),
    .a   (w39),
    .r   (ww44)
  );

  fse_wrap u_wrap_err (
    .clk (clk),
    .a   (thw39),
    .r   (ep44)
  );

  always_comb begin
    zsc44 = 34'(ww44) <<< (30 - FRAC_BITS);
    if (zsc44 > HALF_PI_Q30) begin
      zfold44 = zsc44 - PI_Q30;
      neg44   = 1'b1;
    end else if (zsc44 < -HALF_PI_Q30) begin
      zfold44 = zsc44 + PI_Q30;
      neg44   = 1'b1;
    end else begin
      zfold44 = zsc44;
      neg44   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    z45 <= zfold44;
    lt_line[0] <= '{dx: dd_line[WRAP_LAT].dx, dy: dd_line[WRAP_LAT].dy,
                    ep: ep44, neg: neg44};
    for (int k = 1; k <= CORDIC_STEPS; k++) begin
      lt_line[k] <= lt_line[k-1];
    end
  end

  fse_cordic u_cordic (
    .clk   (clk),
    .z_in  (z45),
    .x_out (x75),
    .y_out (y75)
  );

  always_comb begin
    ey77 = rnd_half(pc77 - ps77, 28);
    if (ey77 > SAT_MAX) begin
      ey77 = SAT_MAX;
    end else if (ey77 < SAT_MIN) begin
      ey77 = SAT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    lt76 <= lt_line[CORDIC_STEPS];
    if (lt_line[CORDIC_STEPS].neg) begin
      cs76 <= 32'(-rnd_half(longint'(x75), 2));
      sn76 <= 32'(-rnd_half(longint'(y75), 2));
    end else begin
      cs76 <= 32'(rnd_half(longint'(x75), 2));
      sn76 <= 32'(rnd_half(longint'(y75), 2));
    end

    pc77 <= longint'(cs76) * longint'(lt76.dy);
    ps77 <= longint'(sn76) * longint'(lt76.dx);
    ep77 <= lt76.ep;

    result.lateral_error <= 32'(ey77);
    result.heading_error <= ep77;
  end

  // A done strobe is raised only for an accepted transaction, at the end of the pipeline.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without a matching transaction");

  // The heading error leaves the wrap unit inside plus or minus pi.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.heading_error <= PI_S) && (result.heading_error >= -PI_S))
    else $error("heading error outside plus or minus pi");

  // The wrapped heading difference feeding the blend is inside plus or minus pi.
  a_blend_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (dhw6 <= PI_S) && (dhw6 >= -PI_S))
    else $error("wrapped heading difference out of range");

  // Sine and cosine stay within unit magnitude in Q28.
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    vld[75] |-> (cs76 <= TRIG_MAX) && (cs76 >= -TRIG_MAX) &&
                (sn76 <= TRIG_MAX) && (sn76 >= -TRIG_MAX))
    else $error("CORDIC output beyond unit magnitude");

endmodule
